/* hw/rtl/lcdns_pkg.sv */
// Shared types, constants and decode functions for the character LCD nibble sequencer.
package lcdns_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int STEP_W          = 5;
    localparam int BYTE_LAST_STEP  = 3;
    localparam int INIT_LAST_STEP  = 28;
    localparam logic [8:0] FIRST_WAKE_MS = 9'd5;

    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;
    localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
    localparam logic [3:0] FOURBIT_NIBBLE = 4'h2;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;

    localparam logic [7:0] ENABLE_HIGH_RESET = 8'd10;
    localparam logic [7:0] ENABLE_LOW_RESET  = 8'd10;
    localparam logic [7:0] SETTLE_RESET      = 8'd2;
    localparam logic [7:0] POWER_UP_RESET    = 8'd50;

    typedef enum logic [1:0] {
        MODE_CMD    = 2'd0,
        MODE_DATA   = 2'd1,
        MODE_CURSOR = 2'd2,
        MODE_INIT   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_ENABLE_HIGH = 2'd0,
        CFG_ENABLE_LOW  = 2'd1,
        CFG_SETTLE      = 2'd2,
        CFG_POWER_UP    = 2'd3
    } cfg_index_t;

    typedef enum logic {
        JOB_BYTE = 1'b0,
        JOB_INIT = 1'b1
    } job_kind_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_BYTE = 2'd1,
        SEQ_INIT = 2'd2
    } seq_state_t;

    typedef enum logic [1:0] {
        EXTRA_NONE   = 2'd0,
        EXTRA_WAKE   = 2'd1,
        EXTRA_SETTLE = 2'd2
    } extra_kind_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] value;
        logic [1:0] row;
        logic [6:0] column;
    } req_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] data_nibble;
        logic       enable;
        logic [8:0] hold_ms;
        logic       last;
    } seg_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       reg_select;
        logic [7:0] byte_val;
    } job_t;

    typedef struct packed {
        logic [7:0] enable_high_ms;
        logic [7:0] enable_low_ms;
        logic [7:0] settle_ms;
        logic [7:0] power_up_ms;
    } cfg_t;

    typedef struct packed {
        logic        is_wait;
        logic [3:0]  nibble;
        logic        enable;
        extra_kind_t extra;
    } init_step_t;

    function automatic logic [7:0] setup_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0:    cmd = CMD_FUNCTION_SET;
            3'd1:    cmd = CMD_DISPLAY_OFF;
            3'd2:    cmd = CMD_CLEAR;
            3'd3:    cmd = CMD_ENTRY_MODE;
            3'd4:    cmd = CMD_DISPLAY_ON;
            default: cmd = CMD_DISPLAY_ON;
        endcase
        return cmd;
    endfunction

    // Step 0 is the power-up wait, steps 1..8 the four wake nibbles,
    // steps 9..28 the five set-up command bytes.
    function automatic init_step_t init_step(input logic [STEP_W-1:0] idx);
        init_step_t      s;
        logic [STEP_W-1:0] k;
        logic [STEP_W-1:0] j;
        logic [7:0]      cmd;
        k = idx - STEP_W'(1);
        j = idx - STEP_W'(9);
        cmd = setup_cmd(j[4:2]);
        s.is_wait = 1'b0;
        s.nibble  = WAKE_NIBBLE;
        s.enable  = 1'b0;
        s.extra   = EXTRA_NONE;
        if (idx == '0) begin
            s.is_wait = 1'b1;
            s.nibble  = 4'h0;
        end else if (idx <= STEP_W'(8)) begin
            s.nibble = (k[2:1] == 2'd3) ? FOURBIT_NIBBLE : WAKE_NIBBLE;
            s.enable = ~k[0];
            if (k[0]) begin
                s.extra = (k[2:1] == 2'd0) ? EXTRA_WAKE : EXTRA_SETTLE;
            end
        end else begin
            s.nibble = j[1] ? cmd[3:0] : cmd[7:4];
            s.enable = ~j[0];
            if (j[1:0] == 2'd3) begin
                s.extra = EXTRA_SETTLE;
            end
        end
        return s;
    endfunction

endpackage

/* hw/rtl/char_lcd_nibble_sequencer_top.sv */
// Top level of the character LCD 4-bit bus sequencer.
//
//  Channel  Ports                  Direction  Carries
//  request  s_valid/s_ready/s_data in         one command, data, cursor or init request
//  segment  m_valid/m_ready/m_data out        one pin segment per transaction
//  config   cfg_wr_en/index/wdata  in         timing register writes, no read-back
//
// A byte request (command, data or cursor) yields four segments, one per cycle while
// the segment side does not stall; init yields 29 segments. The segment counter in
// the back end sets that rate; a four-entry job queue lets requests be accepted while
// earlier ones are still being sent.
// Reset is synchronous and active low; timing registers return to 10, 10, 2, 50 ms.
// Stalls on the segment side fill the queue and then drop s_ready.
module char_lcd_nibble_sequencer_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lcdns_pkg::req_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output lcdns_pkg::seg_t m_data,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_wdata
);
    import lcdns_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic q_wr_en;
    job_t q_wr_data;
    logic q_wr_ready;
    logic q_rd_en;
    job_t q_rd_data;
    logic q_rd_valid;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_ENABLE_HIGH: cfg_next.enable_high_ms = cfg_wdata;
                CFG_ENABLE_LOW:  cfg_next.enable_low_ms  = cfg_wdata;
                CFG_SETTLE:      cfg_next.settle_ms      = cfg_wdata;
                CFG_POWER_UP:    cfg_next.power_up_ms    = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_high_ms <= ENABLE_HIGH_RESET;
            cfg_reg.enable_low_ms  <= ENABLE_LOW_RESET;
            cfg_reg.settle_ms      <= SETTLE_RESET;
            cfg_reg.power_up_ms    <= POWER_UP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcdns_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_wr_en    (q_wr_en),
        .q_wr_data  (q_wr_data),
        .q_wr_ready (q_wr_ready)
    );

    lcdns_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .wr_ready (q_wr_ready),
        .rd_en    (q_rd_en),
        .rd_data  (q_rd_data),
        .rd_valid (q_rd_valid)
    );

    lcdns_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_rd_valid),
        .q_data  (q_rd_data),
        .q_rd_en (q_rd_en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hw/rtl/lcdns_front.sv */
// Front end: accepts requests and turns each into a byte or init job.
module lcdns_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  lcdns_pkg::req_t    s_data,
    output logic               q_wr_en,
    output lcdns_pkg::job_t    q_wr_data,
    input  logic               q_wr_ready
);
    import lcdns_pkg::*;

    logic [7:0] cursor_cmd;

    always_comb begin
        cursor_cmd = {1'b0, s_data.column};
        if (s_data.row == 2'd0) begin
            cursor_cmd = cursor_cmd | ROW0_BASE;
        end else if (s_data.row == 2'd1) begin
            cursor_cmd = cursor_cmd | ROW1_BASE;
        end
    end

    always_comb begin
        q_wr_data.kind       = JOB_BYTE;
        q_wr_data.reg_select = 1'b0;
        q_wr_data.byte_val   = s_data.value;
        case (mode_t'(s_data.mode))
            MODE_CMD: begin
                q_wr_data.reg_select = 1'b0;
            end
            MODE_DATA: begin
                q_wr_data.reg_select = 1'b1;
            end
            MODE_CURSOR: begin
                q_wr_data.byte_val = cursor_cmd;
            end
            MODE_INIT: begin
                q_wr_data.kind = JOB_INIT;
            end
            default: begin
                q_wr_data.kind = JOB_BYTE;
            end
        endcase
    end

    assign s_ready = q_wr_ready;
    assign q_wr_en = s_valid & q_wr_ready;

endmodule

/* hw/rtl/lcdns_queue.sv */
// Short job queue between the front end and the segment sequencer.
module lcdns_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  lcdns_pkg::job_t  wr_data,
    output logic             wr_ready,
    input  logic             rd_en,
    output lcdns_pkg::job_t  rd_data,
    output logic             rd_valid
);
    import lcdns_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

endmodule

/* hw/rtl/lcdns_back.sv */
// Back end: steps through the pin segments of one job and registers each result.
module lcdns_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcdns_pkg::cfg_t  cfg,
    input  logic             q_valid,
    input  lcdns_pkg::job_t  q_data,
    output logic             q_rd_en,
    output logic             m_valid,
    input  logic             m_ready,
    output lcdns_pkg::seg_t  m_data
);
    import lcdns_pkg::*;

    seq_state_t        state_reg, state_next;
    job_t              job_reg, job_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    seg_t              m_data_reg, m_data_next;

    logic       advance;
    logic       seg_fire;
    logic       load_job;
    seg_t       seg;
    init_step_t istep;
    logic [8:0] extra_ms;
    logic [8:0] low_hold;
    seq_state_t job_state;

    assign advance   = !m_valid_reg || m_ready;
    assign job_state = (q_data.kind == JOB_INIT) ? SEQ_INIT : SEQ_BYTE;

    // Segment decode for the current job and step.
    always_comb begin
        istep = init_step(step_reg);
        case (istep.extra)
            EXTRA_WAKE:   extra_ms = FIRST_WAKE_MS;
            EXTRA_SETTLE: extra_ms = {1'b0, cfg.settle_ms};
            default:      extra_ms = '0;
        endcase
        seg.reg_select = job_reg.reg_select;
        seg.data_nibble = step_reg[1] ? job_reg.byte_val[3:0] : job_reg.byte_val[7:4];
        seg.enable     = ~step_reg[0];
        seg.last       = (step_reg == STEP_W'(BYTE_LAST_STEP));
        low_hold       = {1'b0, cfg.enable_low_ms};
        if (state_reg == SEQ_INIT) begin
            seg.reg_select  = 1'b0;
            seg.data_nibble = istep.nibble;
            seg.enable      = istep.enable;
            seg.last        = (step_reg == STEP_W'(INIT_LAST_STEP));
            low_hold        = {1'b0, cfg.enable_low_ms} + extra_ms;
        end
        if (seg.enable) begin
            seg.hold_ms = {1'b0, cfg.enable_high_ms};
        end else begin
            seg.hold_ms = low_hold;
        end
        if (state_reg == SEQ_INIT && istep.is_wait) begin
            seg.hold_ms = {1'b0, cfg.power_up_ms};
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (q_valid) begin
                    state_next = job_state;
                end
            end
            SEQ_BYTE, SEQ_INIT: begin
                if (seg_fire && seg.last) begin
                    state_next = q_valid ? job_state : SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        seg_fire     = 1'b0;
        load_job     = 1'b0;
        job_next     = job_reg;
        step_next    = step_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            SEQ_IDLE: begin
                load_job = q_valid;
            end
            SEQ_BYTE, SEQ_INIT: begin
                seg_fire = advance;
                load_job = q_valid && advance && seg.last;
            end
            default: begin
                load_job = 1'b0;
            end
        endcase
        if (seg_fire) begin
            m_data_next  = seg;
            m_valid_next = 1'b1;
            step_next    = seg.last ? '0 : step_reg + STEP_W'(1);
        end
        if (load_job) begin
            job_next  = q_data;
            step_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    assign q_rd_en = load_job;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_BYTE) |-> (step_reg <= STEP_W'(BYTE_LAST_STEP)))
        else $error("byte job stepped past its last segment");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_INIT) |-> (step_reg <= STEP_W'(INIT_LAST_STEP)))
        else $error("init job stepped past its last segment");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (seg_fire && seg.last) |=> (step_reg == '0))
        else $error("step counter not restarted after the last segment");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_rd_en) |-> (q_valid && (state_reg == SEQ_IDLE || advance)))
        else $error("job taken from an empty queue or while stalled");

endmodule

/* dv/lcd_segment_checker.sv */
// Predictor and scoreboard that check the pin segments produced for each LCD request.
module lcd_segment_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  lcdns_pkg::req_t s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  lcdns_pkg::seg_t m_data,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_wdata,
    output int              mismatches,
    output int              segs_outstanding
);
    import lcdns_pkg::*;

    localparam logic [7:0] ROW0_CMD        = 8'h80;
    localparam logic [7:0] ROW1_CMD        = 8'hC0;
    localparam logic [3:0] WAKE_NIB        = 4'h3;
    localparam logic [3:0] FOURBIT_NIB     = 4'h2;
    localparam logic [8:0] FIRST_SETTLE_MS = 9'd5;
    // Function set, display off, clear, entry mode, display on; first byte in the top bits.
    localparam logic [39:0] SETUP_SEQ      = 40'h28_08_01_06_0C;

    localparam logic [7:0] EN_HIGH_DEFAULT  = 8'd10;
    localparam logic [7:0] EN_LOW_DEFAULT   = 8'd10;
    localparam logic [7:0] SETTLE_DEFAULT   = 8'd2;
    localparam logic [7:0] POWER_UP_DEFAULT = 8'd50;

    logic [7:0] t_en_high  = EN_HIGH_DEFAULT;
    logic [7:0] t_en_low   = EN_LOW_DEFAULT;
    logic [7:0] t_settle   = SETTLE_DEFAULT;
    logic [7:0] t_power_up = POWER_UP_DEFAULT;

    seg_t expected_segs[$];
    int   seg_count = 0;

    initial begin
        mismatches       = 0;
        segs_outstanding = 0;
    end

    function automatic void add_seg(input logic rs, input logic [3:0] nib, input logic en,
                                    input logic [8:0] hold);
        seg_t s;
        s.reg_select  = rs;
        s.data_nibble = nib;
        s.enable      = en;
        s.hold_ms     = hold;
        s.last        = 1'b0;
        expected_segs.push_back(s);
    endfunction

    // One nibble write: enable pulse high, then low with any extra settle time.
    function automatic void add_nibble(input logic rs, input logic [3:0] nib,
                                       input logic [8:0] extra);
        add_seg(rs, nib, 1'b1, {1'b0, t_en_high});
        add_seg(rs, nib, 1'b0, {1'b0, t_en_low} + extra);
    endfunction

    function automatic void add_byte(input logic rs, input logic [7:0] b,
                                     input logic [8:0] extra);
        add_nibble(rs, b[7:4], 9'd0);
        add_nibble(rs, b[3:0], extra);
    endfunction

    function automatic void predict_segments(input req_t r);
        logic [7:0] cmd;
        logic [8:0] settle;
        seg_t       tail;
        int         i;
        settle = {1'b0, t_settle};
        case (r.mode)
            MODE_CMD:  add_byte(1'b0, r.value, 9'd0);
            MODE_DATA: add_byte(1'b1, r.value, 9'd0);
            MODE_CURSOR: begin
                cmd = {1'b0, r.column};
                // Only the two physical rows get a DDRAM base; the others pass through.
                if (r.row == 2'd0) begin
                    cmd = cmd | ROW0_CMD;
                end else if (r.row == 2'd1) begin
                    cmd = cmd | ROW1_CMD;
                end
                add_byte(1'b0, cmd, 9'd0);
            end
            MODE_INIT: begin
                // The power-up wait is emitted even when its length is zero.
                add_seg(1'b0, 4'h0, 1'b0, {1'b0, t_power_up});
                add_nibble(1'b0, WAKE_NIB, FIRST_SETTLE_MS);
                add_nibble(1'b0, WAKE_NIB, settle);
                add_nibble(1'b0, WAKE_NIB, settle);
                add_nibble(1'b0, FOURBIT_NIB, settle);
                for (i = 0; i < 5; i++) begin
                    add_byte(1'b0, SETUP_SEQ[39 - 8*i -: 8], settle);
                end
            end
            default: add_byte(1'b0, r.value, 9'd0);
        endcase
        tail = expected_segs[expected_segs.size() - 1];
        tail.last = 1'b1;
        expected_segs[expected_segs.size() - 1] = tail;
    endfunction

    function automatic void flag(input string field, input int want, input int got);
        mismatches++;
        $display("%0t: segment %0d %s expected %0d, got %0d",
                 $time, seg_count, field, want, got);
    endfunction

    always @(posedge aclk) begin
        seg_t want;
        if (!aresetn) begin
            t_en_high  = EN_HIGH_DEFAULT;
            t_en_low   = EN_LOW_DEFAULT;
            t_settle   = SETTLE_DEFAULT;
            t_power_up = POWER_UP_DEFAULT;
            expected_segs.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_ENABLE_HIGH: t_en_high  = cfg_wdata;
                    CFG_ENABLE_LOW:  t_en_low   = cfg_wdata;
                    CFG_SETTLE:      t_settle   = cfg_wdata;
                    CFG_POWER_UP:    t_power_up = cfg_wdata;
                    default:         t_settle   = t_settle;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_segments(s_data);
            end
            if (m_valid && m_ready) begin
                seg_count++;
                if (expected_segs.size() == 0) begin
                    mismatches++;
                    $display("%0t: segment %0d expected none, got %h",
                             $time, seg_count, m_data);
                end else begin
                    want = expected_segs.pop_front();
                    if (m_data.reg_select !== want.reg_select)
                        flag("reg_select", want.reg_select, m_data.reg_select);
                    if (m_data.data_nibble !== want.data_nibble)
                        flag("data_nibble", want.data_nibble, m_data.data_nibble);
                    if (m_data.enable !== want.enable)
                        flag("enable", want.enable, m_data.enable);
                    if (m_data.hold_ms !== want.hold_ms)
                        flag("hold_ms", want.hold_ms, m_data.hold_ms);
                    if (m_data.last !== want.last)
                        flag("last", want.last, m_data.last);
                end
            end
        end
        segs_outstanding <= expected_segs.size();
    end

endmodule

/* dv/testbench.sv */
// Top of the LCD nibble sequencer testbench: clock, reset, request and config stimulus, verdict.
module testbench;
    import lcdns_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int LONG_HOLD       = 60;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 16;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    req_t       s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    seg_t       m_data;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_wdata = '0;

    int mismatches;
    int segs_outstanding;

    bit idling   = 1'b1;
    bit hold_req = 1'b0;
    int stall_left  = 0;
    int quiet_cycles = 0;
    int seg_total   = 0;
    int req_total   = 0;
    int init_total  = 0;

    always #4 aclk = ~aclk;

    char_lcd_nibble_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lcd_segment_checker seg_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .segs_outstanding (segs_outstanding)
    );

    // Segment side: short random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            seg_total <= seg_total + 1;
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic req_t make_req(input mode_t m, input logic [7:0] value,
                                      input logic [1:0] row, input logic [6:0] column);
        req_t r;
        r.mode   = m;
        r.value  = value;
        r.row    = row;
        r.column = column;
        return r;
    endfunction

    function automatic req_t random_request();
        int    pick;
        mode_t m;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            m = MODE_INIT;
        end else if (pick < 38) begin
            m = MODE_CMD;
        end else if (pick < 70) begin
            m = MODE_DATA;
        end else begin
            m = MODE_CURSOR;
        end
        return make_req(m, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                        7'($urandom_range(0, 127)));
    endfunction

    // Leaves valid high so that a following request can go out back to back.
    task automatic send_req(input req_t r);
        s_data  <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        req_total++;
        if (r.mode == MODE_INIT) init_total++;
    endtask

    task automatic send_with_gap(input req_t r);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        send_req(r);
    endtask

    // Stops offering requests and waits until every predicted segment has been seen.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (segs_outstanding != 0);
    endtask

    task automatic set_timing(input logic [7:0] en_high, input logic [7:0] en_low,
                              input logic [7:0] settle, input logic [7:0] power_up);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ENABLE_HIGH;
        cfg_wdata <= en_high;
        @(posedge aclk);
        cfg_index <= CFG_ENABLE_LOW;
        cfg_wdata <= en_low;
        @(posedge aclk);
        cfg_index <= CFG_SETTLE;
        cfg_wdata <= settle;
        @(posedge aclk);
        cfg_index <= CFG_POWER_UP;
        cfg_wdata <= power_up;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase;
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset timing.
        send_with_gap(make_req(MODE_CMD, 8'h00, 2'd3, 7'h7F));
        send_with_gap(make_req(MODE_CMD, 8'hFF, 2'd0, 7'h00));
        send_with_gap(make_req(MODE_CMD, 8'h01, 2'd1, 7'h2A));
        send_with_gap(make_req(MODE_DATA, 8'h00, 2'd2, 7'h55));
        send_with_gap(make_req(MODE_DATA, 8'hFF, 2'd1, 7'h00));
        send_with_gap(make_req(MODE_DATA, 8'h5A, 2'd0, 7'h7F));
        send_with_gap(make_req(MODE_DATA, 8'hA5, 2'd3, 7'h11));
        send_with_gap(make_req(MODE_CURSOR, 8'hFF, 2'd0, 7'h00));
        send_with_gap(make_req(MODE_CURSOR, 8'h00, 2'd0, 7'h7F));
        send_with_gap(make_req(MODE_CURSOR, 8'h3C, 2'd1, 7'h00));
        send_with_gap(make_req(MODE_CURSOR, 8'hC3, 2'd1, 7'h7F));
        send_with_gap(make_req(MODE_CURSOR, 8'h00, 2'd2, 7'h00));
        send_with_gap(make_req(MODE_CURSOR, 8'hFF, 2'd2, 7'h7F));
        send_with_gap(make_req(MODE_CURSOR, 8'h81, 2'd3, 7'h55));
        send_with_gap(make_req(MODE_CURSOR, 8'h7E, 2'd3, 7'h2A));
        send_with_gap(make_req(MODE_INIT, 8'hFF, 2'd3, 7'h7F));
        send_with_gap(make_req(MODE_CMD, 8'h28, 2'd0, 7'h00));
        send_with_gap(make_req(MODE_INIT, 8'h00, 2'd0, 7'h00));
        send_with_gap(make_req(MODE_DATA, 8'h41, 2'd2, 7'h40));

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: set_timing(8'd255, 8'd255, 8'd255, 8'd255);
                1: set_timing(8'd1, 8'd1, 8'd0, 8'd0);
                default: set_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            idling = (phase != 3) && (phase != PHASES - 1);
            // Hold the segment side off while requests keep coming, so the queue fills.
            if (phase == 2) hold_req = 1'b1;
            send_with_gap(make_req(MODE_INIT, 8'($urandom_range(0, 255)),
                                   2'($urandom_range(0, 3)), 7'($urandom_range(0, 127))));
            for (n = 1; n < ITEMS_PER_PHASE; n++) begin
                send_with_gap(random_request());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d requests (%0d power-up inits) and checked %0d pin segments",
                 req_total, init_total, seg_total);
        $display("over %0d timing settings, with random stalls and one long output hold-off.",
                 PHASES + 1);
        if (mismatches == 0 && segs_outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* char_lcd_nibble_sequencer_top.f */
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_front.sv
hw/rtl/lcdns_queue.sv
hw/rtl/lcdns_back.sv
hw/rtl/char_lcd_nibble_sequencer_top.sv
dv/lcd_segment_checker.sv
dv/testbench.sv
